>>> sv/llts_pkg.sv
package llts_pkg;
    localparam int MAX_TASKS = 64;
    localparam int TIME_BITS = 20;
    localparam int LAX_BITS = TIME_BITS + 4;
    localparam int IDX_BITS = 6;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // best candidate carried along the chain
    typedef struct packed {
        logic                       good;
        logic                       bad;
        logic signed [LAX_BITS-1:0] lax;
        logic [TIME_BITS-1:0]       due;
        logic [IDX_BITS-1:0]        good_idx;
        logic [IDX_BITS-1:0]        bad_idx;
    } cand_t;
endpackage

>>> sv/llts_cell.sv
module llts_cell
    import llts_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load_en,
    input  logic [TIME_BITS-1:0] rel_in,
    input  logic [TIME_BITS-1:0] run_in,
    input  logic [TIME_BITS-1:0] due_in,
    input  logic                 in_use,
    input  logic [TIME_BITS:0]   now,
    input  cand_t                cand_in,
    output cand_t                cand_out,
    input  logic                 upd_en,
    input  logic                 run_sel,
    input  logic [IDX_BITS-1:0]  pick_idx,
    output logic                 done,
    output logic                 wait_out,
    output logic                 fin_out,
    output logic                 late_out
);
    localparam logic signed [LAX_BITS-1:0] LAX_MIN = {1'b1, {(LAX_BITS-1){1'b0}}};

    logic [TIME_BITS-1:0] rel_reg, due_reg, rem_reg;
    logic signed [LAX_BITS-1:0] lax_reg;
    logic done_reg;
    logic waiting, neg, mine;
    cand_t cand_reg, cand_next;

    assign waiting = in_use && !done_reg && ({1'b0, rel_reg} <= now);
    assign neg = lax_reg[LAX_BITS-1];
    assign done = done_reg;
    assign wait_out = waiting;
    assign mine = run_sel && (pick_idx == IDX_BITS'(IDX));
    assign fin_out = mine && (rem_reg <= TIME_BITS'(1));
    assign late_out = mine && neg;
    assign cand_out = cand_reg;

    always_comb
    begin
        cand_next = cand_in;
        if (waiting)
        begin
            if (neg)
            begin
                cand_next.bad = 1'b1;
                cand_next.bad_idx = IDX_BITS'(IDX);
            end
            else if (!cand_in.good || lax_reg < cand_in.lax ||
                     (lax_reg == cand_in.lax && due_reg < cand_in.due))
            begin
                cand_next.good = 1'b1;
                cand_next.lax = lax_reg;
                cand_next.due = due_reg;
                cand_next.good_idx = IDX_BITS'(IDX);
            end
        end
    end

    // hand the candidate to the next cell every cycle
    always_ff @(posedge clk)
    begin
        cand_reg <= cand_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else if (load_en)
            done_reg <= 1'b0;
        else if (upd_en && waiting && fin_out)
            done_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            rel_reg <= rel_in;
            due_reg <= due_in;
            rem_reg <= run_in;
            lax_reg <= LAX_BITS'(due_in) - LAX_BITS'(rel_in) - LAX_BITS'(run_in);
        end
        else if (upd_en && waiting)
        begin
            if (mine)
                rem_reg <= (rem_reg <= TIME_BITS'(1)) ? '0 : rem_reg - TIME_BITS'(1);
            else if (lax_reg != LAX_MIN)
                lax_reg <= lax_reg - LAX_BITS'(1);
        end
    end
endmodule

>>> sv/least_laxity_task_scheduler.sv
// Least-laxity-first scheduler.
// in channel (in_valid/in_ready): opcode 0 loads a task into slot, opcode 1
// advances one tick. out channel (out_valid/out_ready): one beat per input
// beat with chosen_task, finished, late and all_complete.
// cfg channel (cfg_valid/cfg_ready): task_count, written while idle.
// Each slot is a cell of a chain; the candidate moves one cell per cycle.
// A load beat goes from accept through S_UPD to S_OUT; a tick beat first
// stays in S_SEL while the candidate crosses the 64 cells and settles, then
// passes S_UPD to update and S_OUT. One item is in flight at a time, so no
// new beat is accepted before the result beat is taken by the receiver.
// Reset: all done marks clear, time starts at one, task_count is one.
// A stalled receiver holds the result; no new beat is accepted until taken.
module least_laxity_task_scheduler
    import llts_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 opcode,
    input  logic [5:0]           slot,
    input  logic [TIME_BITS-1:0] release_time,
    input  logic [TIME_BITS-1:0] run_length,
    input  logic [TIME_BITS-1:0] due_time,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [6:0]           chosen_task,
    output logic                 finished,
    output logic                 late,
    output logic                 all_complete,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [6:0]           task_count
);
    localparam int N = MAX_TASKS;
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SEL = 2'd1;
    localparam logic [1:0] S_UPD = 2'd2;
    localparam logic [1:0] S_OUT = 2'd3;
    localparam logic [6:0] SEL_LAST = 7'(N);

    logic [1:0] state_reg, state_next;
    logic [6:0] cnt_reg;
    logic [6:0] sel_cnt_reg;
    logic [TIME_BITS:0] now_reg;
    logic op_reg;
    logic [6:0] chosen_reg;
    logic fin_reg, late_reg, allc_reg;
    logic [IDX_BITS-1:0] pick_reg;
    logic run_reg;
    logic accept;
    logic sel_done;
    logic tick_upd;
    cand_t chain [N+1];
    logic [N-1:0] done_v, wait_v, fin_v, late_v, use_v;

    assign accept = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign sel_done = (state_reg == S_SEL) && (sel_cnt_reg == SEL_LAST);
    assign tick_upd = (state_reg == S_UPD) && (op_reg == OP_TICK);
    assign chosen_task = chosen_reg;
    assign finished = fin_reg;
    assign late = late_reg;
    assign all_complete = allc_reg;
    assign chain[0] = '0;

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            assign use_v[g] = (32'(cnt_reg) > g);
            llts_cell #(.IDX(g)) u_cell (
                .clk(clk), .rst_n(rst_n),
                .load_en(accept && opcode == OP_LOAD && 32'(slot) == g),
                .rel_in(release_time), .run_in(run_length), .due_in(due_time),
                .in_use(use_v[g]), .now(now_reg),
                .cand_in(chain[g]), .cand_out(chain[g+1]),
                .upd_en(tick_upd), .run_sel(run_reg),
                .pick_idx(pick_reg), .done(done_v[g]), .wait_out(wait_v[g]),
                .fin_out(fin_v[g]), .late_out(late_v[g])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (accept) state_next = (opcode == OP_TICK) ? S_SEL : S_UPD;
            S_SEL: if (sel_done) state_next = S_UPD;
            S_UPD: state_next = S_OUT;
            S_OUT: if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= 7'd1;
            sel_cnt_reg <= 7'd0;
            now_reg <= (TIME_BITS+1)'(1);
            op_reg <= OP_LOAD;
            run_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                cnt_reg <= (32'(task_count) > N) ? 7'(N) : task_count;
            if (accept)
            begin
                op_reg <= opcode;
                run_reg <= 1'b0;
                sel_cnt_reg <= 7'd0;
            end
            else if (state_reg == S_SEL && !sel_done)
                sel_cnt_reg <= sel_cnt_reg + 7'd1;
            if (sel_done)
                run_reg <= chain[N].good || chain[N].bad;
            if (tick_upd && !(&now_reg))
                now_reg <= now_reg + (TIME_BITS+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (sel_done)
            pick_reg <= chain[N].good ? chain[N].good_idx : chain[N].bad_idx;
        if (state_reg == S_UPD)
        begin
            chosen_reg <= run_reg ? 7'(pick_reg) + 7'd1 : 7'd0;
            fin_reg <= |fin_v;
            late_reg <= |late_v;
            allc_reg <= &(done_v | ~use_v | (fin_v & wait_v));
        end
    end

`ifndef ASSERT_OFF
    a_one_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(fin_v)) else $error("several cells finish at once");
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD && op_reg == OP_LOAD) |=> chosen_reg == 7'd0)
        else $error("load beat reports a task");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(chosen_reg))
        else $error("result dropped under stall");
`endif
endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import llts_pkg::*;

    localparam int SLOTS = 64;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [6:0] task_id;
        logic       fin;
        logic       late_run;
        logic       all_done;
    } sched_beat_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        opcode;
    logic [5:0]  slot;
    logic [19:0] release_time;
    logic [19:0] run_length;
    logic [19:0] due_time;
    logic        out_valid;
    logic        out_ready;
    logic [6:0]  chosen_task;
    logic        finished;
    logic        late;
    logic        all_complete;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [6:0]  task_count;

    least_laxity_task_scheduler uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .slot         (slot),
        .release_time (release_time),
        .run_length   (run_length),
        .due_time     (due_time),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .chosen_task  (chosen_task),
        .finished     (finished),
        .late         (late),
        .all_complete (all_complete),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .task_count   (task_count)
    );

    // scheduler shadow state
    logic [19:0]        rel_tab [SLOTS];
    logic [19:0]        due_tab [SLOTS];
    logic [19:0]        rem_tab [SLOTS];
    logic signed [23:0] lax_tab [SLOTS];
    bit                 done_tab [SLOTS];
    logic [20:0]        now_tick;
    int                 slots_used;

    sched_beat_t pending_beats[$];
    int          mismatches;
    int          cycles;
    bit          quiet_mode;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic bit all_slots_done();
        for (int i = 0; i < slots_used; i++)
            if (!done_tab[i])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic sched_beat_t schedule_step(logic op, logic [5:0] s, logic [19:0] r,
                                                  logic [19:0] len, logic [19:0] d);
        sched_beat_t res;
        int          lx;
        bit          have_good;
        bit          have_late;
        int          good;
        int          bad;
        int          pick;
        res = '0;
        have_good = 1'b0;
        have_late = 1'b0;
        good = 0;
        bad = 0;
        if (op == OP_LOAD)
        begin
            lx = int'(d) - int'(r) - int'(len);
            rel_tab[s] = r;
            rem_tab[s] = len;
            due_tab[s] = d;
            lax_tab[s] = lx[23:0];
            done_tab[s] = 1'b0;
        end
        else
        begin
            for (int i = 0; i < slots_used; i++)
            begin
                if (done_tab[i] || {1'b0, rel_tab[i]} > now_tick)
                    continue;
                if (lax_tab[i] < 0)
                begin
                    have_late = 1'b1;
                    bad = i;
                end
                else if (!have_good || lax_tab[i] < lax_tab[good] ||
                         (lax_tab[i] == lax_tab[good] && due_tab[i] < due_tab[good]))
                begin
                    have_good = 1'b1;
                    good = i;
                end
            end
            pick = have_good ? good : bad;
            for (int i = 0; i < slots_used; i++)
            begin
                if (done_tab[i] || {1'b0, rel_tab[i]} > now_tick)
                    continue;
                if ((have_good || have_late) && i == pick)
                begin
                    res.task_id = 7'(i + 1);
                    res.late_run = lax_tab[i] < 0;
                    if (rem_tab[i] <= 1)
                    begin
                        rem_tab[i] = '0;
                        done_tab[i] = 1'b1;
                        res.fin = 1'b1;
                    end
                    else
                        rem_tab[i] = rem_tab[i] - 1;
                end
                else if (lax_tab[i] > -(24'sd1 <<< 23))
                    lax_tab[i] = lax_tab[i] - 1;
            end
            if (now_tick != '1)
                now_tick = now_tick + 1;
        end
        res.all_done = all_slots_done();
        return res;
    endfunction

    // receiver: check each beat, draw the stall before the next one
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        sched_beat_t want;
        sched_beat_t got;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
        end
        else if (out_valid && out_ready)
        begin
            got = {chosen_task, finished, late, all_complete};
            if (pending_beats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %p", got);
            end
            else
            begin
                want = pending_beats.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp task=%0d fin=%b late=%b all=%b",
                                 want.task_id, want.fin, want.late_run, want.all_done,
                                 " got task=%0d fin=%b late=%b all=%b",
                                 got.task_id, got.fin, got.late_run, got.all_done);
                end
            end
            stall_left = quiet_mode ? 0 : $urandom_range(0, 7);
            out_ready <= (stall_left == 0);
        end
        else
        begin
            if (stall_left > 0)
                stall_left--;
            out_ready <= (stall_left == 0);
        end
    end

    task automatic send_item(logic op, logic [5:0] s, logic [19:0] r, logic [19:0] len,
                             logic [19:0] d);
        int gap;
        gap = quiet_mode ? 0 : $urandom_range(0, 7);
        repeat (gap)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        slot <= s;
        release_time <= r;
        run_length <= len;
        due_time <= d;
        do
            @(posedge clk);
        while (!in_ready);
        pending_beats = {pending_beats, schedule_step(op, s, r, len, d)};
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_beats.size() != 0);
        // let the last beat clear the pipeline
        repeat (6) @(posedge clk);
    endtask

    task automatic write_count(logic [6:0] v);
        drain();
        cfg_valid <= 1'b1;
        task_count <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        slots_used = (v > SLOTS) ? SLOTS : v;
    endtask

    task automatic tick();
        send_item(OP_TICK, 6'($urandom), 20'($urandom), 20'($urandom), 20'($urandom));
    endtask

    task automatic test_directed();
        send_item(OP_LOAD, 6'd0, 20'd0, 20'd3, 20'd5);
        repeat (4) tick();
        // task with no run time finishes on first pick
        send_item(OP_LOAD, 6'd0, 20'd0, 20'd0, 20'd9);
        repeat (2) tick();
        // late from the start
        send_item(OP_LOAD, 6'd0, 20'd0, 20'd2, 20'd0);
        repeat (3) tick();
        // not yet released, out of use slot at extremes
        send_item(OP_LOAD, 6'd0, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
        send_item(OP_LOAD, 6'd63, 20'hFFFFF, 20'hFFFFF, 20'd0);
        repeat (2) tick();
        send_item(OP_LOAD, 6'd0, 20'd0, 20'hFFFFF, 20'hFFFFF);
        repeat (2) tick();
    endtask

    task automatic test_fill_all_slots();
        for (int i = 0; i < SLOTS; i++)
            send_item(OP_LOAD, 6'(i), 20'(now_tick) + 20'($urandom_range(0, 3)),
                      20'($urandom_range(1, 4)), 20'(now_tick) + 20'($urandom_range(0, 12)));
        write_count(7'd64);
        repeat (20) tick();
    endtask

    task automatic test_random_phase(logic [6:0] cnt, int items);
        logic [5:0]  s;
        logic [19:0] r;
        logic [19:0] len;
        logic [19:0] d;
        int          lim;
        write_count(cnt);
        lim = (slots_used == 0) ? 64 : slots_used;
        for (int n = 0; n < items; n++)
        begin
            if (n % 100 == 0)
                quiet_mode = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < 30)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    s = 6'($urandom);
                    r = 20'($urandom);
                    len = 20'($urandom);
                    d = 20'($urandom);
                end
                else
                begin
                    s = 6'($urandom_range(0, lim - 1));
                    r = 20'(now_tick) + 20'($urandom_range(0, 4)) - 20'($urandom_range(0, 2));
                    len = 20'($urandom_range(0, 6));
                    d = r + len + 20'($urandom_range(0, 10)) - 20'($urandom_range(0, 3));
                end
                send_item(OP_LOAD, s, r, len, d);
            end
            else
                tick();
        end
        quiet_mode = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = OP_LOAD;
        slot = '0;
        release_time = '0;
        run_length = '0;
        due_time = '0;
        cfg_valid = 1'b0;
        task_count = 7'd1;
        mismatches = 0;
        cycles = 0;
        quiet_mode = 1'b0;
        now_tick = 21'd1;
        slots_used = 1;
        for (int i = 0; i < SLOTS; i++)
        begin
            rel_tab[i] = '0;
            due_tab[i] = '0;
            rem_tab[i] = '0;
            lax_tab[i] = '0;
            done_tab[i] = 1'b0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_fill_all_slots();
        test_random_phase(7'd1, 150);
        test_random_phase(7'd0, 40);
        test_random_phase(7'd2, 250);
        test_random_phase(7'd5, 300);
        test_random_phase(7'd127, 300);
        test_random_phase(7'($urandom_range(3, 63)), 300);
        test_random_phase(7'd64, 300);
        drain();

        if (mismatches == 0 && pending_beats.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
